[rtl/srtf_pkg.sv]
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and codes of the shortest-remaining-time-first tick scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_ALL_DONE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  task_id;
        logic        idle;
        logic        finished;
        logic [15:0] completion_time;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        all_done;
    } t_rsp;

endpackage

[rtl/srtf_if.sv]
// ----------------------------------------------------------------------------
// srtf_if
// Request and response channels of the scheduler (valid/ready handshake).
// ----------------------------------------------------------------------------
interface srtf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] arrival;
    logic [15:0] burst;

    modport source (output valid, output operation, output arrival, output burst,
                    input ready);
    modport sink (input valid, input operation, input arrival, input burst,
                  output ready);
endinterface

interface srtf_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  task_id;
    logic        idle;
    logic        finished;
    logic [15:0] completion_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;

    modport source (output valid, output status, output task_id, output idle,
                    output finished, output completion_time, output turnaround,
                    output waiting, output all_done, input ready);
    modport sink (input valid, input status, input task_id, input idle,
                  input finished, input completion_time, input turnaround,
                  input waiting, input all_done, output ready);
endinterface

[rtl/srtf_ram.sv]
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/srtf_alu.sv]
// ----------------------------------------------------------------------------
// srtf_alu
// Shared subtract/compare unit: difference and borrow (a < b).
// ----------------------------------------------------------------------------
module srtf_alu #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_borrow
);

    logic [WIDTH:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[WIDTH-1:0];
    assign o_borrow = w_full[WIDTH];

endmodule

[rtl/srtf_tick_scheduler_top.sv]
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_top
// Preemptive shortest-remaining-time-first scheduler over a task table.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: operation (load, tick, clear, no-op) with the
//   arrival time and burst length of a task to load. o_rsp returns exactly one
//   response per request: status, task number, idle/finished flags, the
//   completion, turnaround and waiting times of a finishing task, all_done.
//   Load, clear, no-op and a tick with every task done answer directly:
//   the response register is loaded at the edge that accepts the request.
//   A working tick scans the table, one entry per cycle through the task RAM
//   read port, then updates the selected entry; a task that finishes also
//   passes through the finish state, which sends its response.
//   One request is in work at a time; i_req.ready is high only when the
//   sequencer is idle and the response register is empty or being taken.
//   A stalled receiver holds the response; the next request then waits.
//   Reset clears time, the task and done counts and the handshake state;
//   the task RAM itself is not cleared, since only loaded entries are read.
// ----------------------------------------------------------------------------
module srtf_tick_scheduler_top
    import srtf_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srtf_req_if.sink    i_req,
    srtf_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TB = TIME_BITS;
    localparam int RW = 3 * TB;

    // Sequencer and counters
    t_state          r_state, n_state;
    logic [CW-1:0]   r_task_count, n_task_count;
    logic [CW-1:0]   r_done_count, n_done_count;
    logic [TB-1:0]   r_now, n_now;

    // Scan pipeline: read issue, then compare on registered read data
    logic [IW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_issuing, n_issuing;
    logic            r_cmp_vld, n_cmp_vld;
    logic            r_cmp_last, n_cmp_last;
    logic [IW-1:0]   r_cmp_idx, n_cmp_idx;

    // Best candidate so far
    logic            r_found, n_found;
    logic [IW-1:0]   r_best_idx, n_best_idx;
    logic [TB-1:0]   r_best_arr, n_best_arr;
    logic [TB-1:0]   r_best_bur, n_best_bur;
    logic [TB-1:0]   r_best_rem, n_best_rem;

    // Finishing-task results
    logic [TB-1:0]   r_ct, n_ct;
    logic [TB-1:0]   r_tat, n_tat;

    // Response register
    logic            r_out_vld, n_out_vld;
    t_rsp            r_rsp, n_rsp;

    // RAM
    logic            w_we;
    logic [IW-1:0]   w_waddr;
    logic [RW-1:0]   w_wdata;
    logic [RW-1:0]   w_rdata;
    logic [TB-1:0]   w_rd_arr, w_rd_bur, w_rd_rem;

    // Shared unit
    logic [TB-1:0]   w_alu_a, w_alu_b, w_alu_diff;
    logic            w_alu_borrow;

    logic            w_req_fire;
    logic            w_all_done_now;
    logic [IW-1:0]   w_last;
    logic [TB-1:0]   w_in_arr, w_in_bur;
    logic [TB-1:0]   w_now_inc;
    logic            w_cand;
    logic [31:0]     w_tid_load, w_tid_run;
    logic [31:0]     w_ct32, w_tat32, w_wt32;
    logic [TB-1:0]   w_wt;
    logic [CW-1:0]   w_cnt_plus, w_done_plus;

    srtf_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    srtf_alu #(
        .WIDTH (TB)
    ) u_alu (
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_diff   (w_alu_diff),
        .o_borrow (w_alu_borrow)
    );

    assign i_req.ready    = (r_state == S_IDLE) && (!r_out_vld || o_rsp.ready);
    assign w_req_fire     = i_req.valid && i_req.ready;
    assign w_all_done_now = (r_done_count >= r_task_count);
    assign w_last         = IW'(r_task_count - CW'(1));
    assign w_in_arr       = TB'(i_req.arrival);
    assign w_in_bur       = TB'(i_req.burst);
    assign w_now_inc      = (r_now == {TB{1'b1}}) ? r_now : r_now + TB'(1);
    assign w_cnt_plus     = r_task_count + CW'(1);
    assign w_done_plus    = r_done_count + CW'(1);

    assign w_rd_arr = w_rdata[RW-1:2*TB];
    assign w_rd_bur = w_rdata[2*TB-1:TB];
    assign w_rd_rem = w_rdata[TB-1:0];

    // Route the shared unit: remaining compare while scanning, turnaround in
    // update, waiting in finish.
    always_comb begin
        case (r_state)
            S_SCAN: begin
                w_alu_a = w_rd_rem;
                w_alu_b = r_best_rem;
            end
            S_UPDATE: begin
                w_alu_a = w_now_inc;
                w_alu_b = r_best_arr;
            end
            S_FINISH: begin
                w_alu_a = r_tat;
                w_alu_b = r_best_bur;
            end
            default: begin
                w_alu_a = r_now;
                w_alu_b = r_now;
            end
        endcase
    end

    // Entry qualifies: arrived, has work, and beats the best so far (strictly,
    // so the lowest number keeps a tie).
    assign w_cand = (w_rd_arr <= r_now) && (w_rd_rem != '0) &&
                    (!r_found || w_alu_borrow);

    assign w_tid_load = 32'(r_task_count) + 32'd1;
    assign w_tid_run  = 32'(r_best_idx) + 32'd1;
    assign w_wt       = w_alu_borrow ? '0 : w_alu_diff;
    assign w_ct32     = 32'(r_ct);
    assign w_tat32    = 32'(r_tat);
    assign w_wt32     = 32'(w_wt);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_req_fire && (t_op'(i_req.operation) == OP_TICK) &&
                    !w_all_done_now) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cmp_vld && r_cmp_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_found && (r_best_rem == TB'(1))) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_task_count = r_task_count;
        n_done_count = r_done_count;
        n_now        = r_now;
        n_rd_idx     = r_rd_idx;
        n_issuing    = r_issuing;
        n_cmp_vld    = 1'b0;
        n_cmp_last   = 1'b0;
        n_cmp_idx    = r_rd_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_arr   = r_best_arr;
        n_best_bur   = r_best_bur;
        n_best_rem   = r_best_rem;
        n_ct         = r_ct;
        n_tat        = r_tat;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_rsp        = r_rsp;
        w_we         = 1'b0;
        w_waddr      = r_task_count[IW-1:0];
        w_wdata      = {w_in_arr, w_in_bur, w_in_bur};

        case (r_state)
            S_IDLE: begin
                if (w_req_fire) begin
                    n_rsp = '0;
                    case (t_op'(i_req.operation))
                        OP_LOAD: begin
                            if (r_task_count >= CW'(MAX_TASKS)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                w_we         = 1'b1;
                                n_task_count = w_cnt_plus;
                                if (w_in_bur == '0) begin
                                    n_done_count = w_done_plus;
                                end
                                n_rsp.task_id = w_tid_load[4:0];
                            end
                        end
                        OP_TICK: begin
                            if (w_all_done_now) begin
                                n_rsp.status = ST_ALL_DONE;
                                n_rsp.idle   = 1'b1;
                            end else begin
                                n_rd_idx  = '0;
                                n_issuing = 1'b1;
                                n_found   = 1'b0;
                            end
                        end
                        OP_CLEAR: begin
                            n_task_count = '0;
                            n_done_count = '0;
                            n_now        = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.all_done = (n_done_count >= n_task_count);
                    // A working tick answers later.
                    n_out_vld = !((t_op'(i_req.operation) == OP_TICK) && !w_all_done_now);
                end
            end
            S_SCAN: begin
                if (r_issuing) begin
                    n_cmp_vld  = 1'b1;
                    n_cmp_idx  = r_rd_idx;
                    n_cmp_last = (r_rd_idx == w_last);
                    if (r_rd_idx == w_last) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + IW'(1);
                    end
                end
                if (r_cmp_vld && w_cand) begin
                    n_found    = 1'b1;
                    n_best_idx = r_cmp_idx;
                    n_best_arr = w_rd_arr;
                    n_best_bur = w_rd_bur;
                    n_best_rem = w_rd_rem;
                end
            end
            S_UPDATE: begin
                n_now = w_now_inc;
                n_rsp = '0;
                if (!r_found) begin
                    n_rsp.idle     = 1'b1;
                    n_rsp.all_done = w_all_done_now;
                    n_out_vld      = 1'b1;
                end else begin
                    // Run the chosen task one unit.
                    w_we    = 1'b1;
                    w_waddr = r_best_idx;
                    w_wdata = {r_best_arr, r_best_bur, r_best_rem - TB'(1)};
                    n_ct    = w_now_inc;
                    n_tat   = w_alu_diff;
                    n_rsp.task_id = w_tid_run[4:0];
                    if (r_best_rem == TB'(1)) begin
                        n_done_count = w_done_plus;
                    end else begin
                        n_rsp.all_done = w_all_done_now;
                        n_out_vld      = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                n_rsp.finished        = 1'b1;
                n_rsp.completion_time = w_ct32[15:0];
                n_rsp.turnaround      = w_tat32[15:0];
                n_rsp.waiting         = w_wt32[15:0];
                n_rsp.all_done        = w_all_done_now;
                n_out_vld             = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_count <= '0;
            r_done_count <= '0;
            r_now        <= '0;
            r_issuing    <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_task_count <= n_task_count;
            r_done_count <= n_done_count;
            r_now        <= n_now;
            r_issuing    <= n_issuing;
            r_cmp_vld    <= n_cmp_vld;
            r_found      <= n_found;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_cmp_last <= n_cmp_last;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best_arr <= n_best_arr;
        r_best_bur <= n_best_bur;
        r_best_rem <= n_best_rem;
        r_ct       <= n_ct;
        r_tat      <= n_tat;
        r_rsp      <= n_rsp;
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_rsp.status;
    assign o_rsp.task_id         = r_rsp.task_id;
    assign o_rsp.idle            = r_rsp.idle;
    assign o_rsp.finished        = r_rsp.finished;
    assign o_rsp.completion_time = r_rsp.completion_time;
    assign o_rsp.turnaround      = r_rsp.turnaround;
    assign o_rsp.waiting         = r_rsp.waiting;
    assign o_rsp.all_done        = r_rsp.all_done;

endmodule

[rtl/srtf_checker.sv]
// ----------------------------------------------------------------------------
// srtf_checker
// Port-level assertions for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module srtf_checker
    import srtf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input logic [4:0]  i_task_id,
    input logic        i_idle,
    input logic        i_finished,
    input logic [15:0] i_waiting
);

    // Hold a stalled response.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_status) && $stable(i_task_id) && $stable(i_idle) &&
            $stable(i_finished) && $stable(i_waiting))
        else $error("response changed while stalled");

    // After a request, either its response shows or the block stays busy.
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid || !i_req_ready)
        else $error("request taken with neither response nor busy");

    // A finishing task ran this tick.
    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_finished |->
            !i_idle && (i_task_id != 5'd0) && (i_status == ST_OK))
        else $error("finished response without a running task");

endmodule

bind srtf_tick_scheduler_top srtf_checker u_srtf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_task_id   (o_rsp.task_id),
    .i_idle      (o_rsp.idle),
    .i_finished  (o_rsp.finished),
    .i_waiting   (o_rsp.waiting)
);
